// File: sv/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply unit.
package mvm_pkg;

  localparam int unsigned ElemW     = 16;
  localparam int unsigned Elems     = 4;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned StoreSlots = 256;
  localparam int unsigned WordW     = ElemW * Elems;
  localparam int unsigned ProdW     = 2 * ElemW;
  localparam int unsigned ChunkW    = ProdW + 2;
  localparam int unsigned SumW      = 48;
  localparam int unsigned RowW      = 10;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqMult = 1'b1;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [RowW-1:0]         row_t;
  typedef logic [WordW-1:0]        word_t;

  typedef struct packed {
    logic adv;
    logic load;
    logic mult;
    logic row_end;
  } merge_ctrl_t;

endpackage

// File: sv/mvm_lane.sv
// One multiply lane: registered product of a matrix element and a vector element.
module mvm_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          use_i,
  input  mvm_pkg::elem_t a_i,
  input  mvm_pkg::elem_t b_i,
  output mvm_pkg::prod_t prod_o
);
  import mvm_pkg::*;

  prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= use_i ? prod_t'(a_i) * prod_t'(b_i) : '0;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: sv/mvm_merge.sv
// Merging stage: sums the lane products into the saturating row accumulator.
module mvm_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mvm_pkg::merge_ctrl_t ctrl_i,
  input  mvm_pkg::prod_t       prod_i [mvm_pkg::Elems],
  output mvm_pkg::row_t        row_index_o,
  output mvm_pkg::sum_t        row_sum_o
);
  import mvm_pkg::*;

  sum_t                     acc_q, acc_d;
  row_t                     cnt_q, cnt_d;
  logic signed [ChunkW-1:0] chunk;
  logic signed [SumW:0]     sum_wide;
  sum_t                     sat_val;

  always_comb begin
    chunk = '0;
    for (int k = 0; k < Elems; k++) begin
      chunk = chunk + ChunkW'(prod_i[k]);
    end
    sum_wide = (SumW+1)'(acc_q) + (SumW+1)'(chunk);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sat_val = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sat_val = sum_wide[SumW-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (ctrl_i.adv) begin
      if (ctrl_i.load) begin
        acc_d = '0;
        cnt_d = '0;
      end else if (ctrl_i.mult) begin
        if (ctrl_i.row_end) begin
          acc_d = '0;
          cnt_d = cnt_q + row_t'(1);
        end else begin
          acc_d = sat_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  assign row_index_o = cnt_q;
  assign row_sum_o   = sat_val;

endmodule

// File: sv/matrix_vector_multiply_unit.sv
// Top level of the matrix-vector multiply unit with vector store and output register.
//
// The unit takes one four-element beat per clock cycle, load or matrix, with no bubbles
// between beats unless a row result is held back. A beat reads its vector chunk from the
// store at acceptance, the four lanes register their products as it enters the multiply
// stage, and the merging stage adds them to the row accumulator as it leaves, with a
// row-ending beat loading its row result into the output register. The rate is set by one
// 16x16 multiply per lane per cycle and the single accumulate add. While a row result waits
// in the output register, beats that end no row keep flowing through the merging stage,
// but the next row-ending beat holds in the multiply stage and every beat behind it waits.
module matrix_vector_multiply_unit #(
  parameter int unsigned VEC_LEN = 1024,
  parameter int unsigned LANES   = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  mvm_pkg::idx_t  chunk_index_i,
  input  mvm_pkg::elem_t elem_0_i,
  input  mvm_pkg::elem_t elem_1_i,
  input  mvm_pkg::elem_t elem_2_i,
  input  mvm_pkg::elem_t elem_3_i,
  input  logic           row_end_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mvm_pkg::row_t  row_index_o,
  output mvm_pkg::sum_t  row_sum_o
);
  import mvm_pkg::*;

  localparam int unsigned StoreDepth = VEC_LEN / LANES;

  word_t store_q [StoreSlots];

  elem_t in_elem [Elems];
  logic  in_acc;
  logic  in_range;

  logic  s1_valid_q;
  logic  s1_type_q;
  logic  s1_row_end_q;
  logic  s1_in_range_q;
  elem_t s1_elem_q [Elems];
  word_t s1_word_q;

  logic  s2_valid_q;
  logic  s2_type_q;
  logic  s2_row_end_q;
  prod_t s2_prod [Elems];

  logic  out_valid_q;
  row_t  out_row_q;
  sum_t  out_sum_q;

  logic  out_free, s2_emits, adv2, s2_free, adv1;
  row_t  merge_row;
  sum_t  merge_sum;
  merge_ctrl_t ctrl;

  assign in_elem[0] = elem_0_i;
  assign in_elem[1] = elem_1_i;
  assign in_elem[2] = elem_2_i;
  assign in_elem[3] = elem_3_i;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_emits   = s2_type_q == ReqMult && s2_row_end_q;
  assign adv2       = s2_valid_q && (!s2_emits || out_free);
  assign s2_free    = !s2_valid_q || adv2;
  assign adv1       = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || adv1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = 32'(chunk_index_i) < StoreDepth;

  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == ReqLoad && in_range) begin
      store_q[chunk_index_i] <= {elem_3_i, elem_2_i, elem_1_i, elem_0_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q     <= store_q[chunk_index_i];
      s1_type_q     <= req_type_i;
      s1_row_end_q  <= row_end_i;
      s1_in_range_q <= in_range;
      for (int k = 0; k < Elems; k++) begin
        s1_elem_q[k] <= in_elem[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_type_q    <= s1_type_q;
      s2_row_end_q <= s1_row_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        s2_valid_q <= 1'b1;
      end else if (adv2) begin
        s2_valid_q <= 1'b0;
      end
      if (adv2 && s2_emits) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < Elems; k++) begin : g_lane
    mvm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv1),
      .use_i  (s1_in_range_q && (k < LANES)),
      .a_i    (s1_elem_q[k]),
      .b_i    (elem_t'(s1_word_q[k*ElemW +: ElemW])),
      .prod_o (s2_prod[k])
    );
  end

  assign ctrl.adv     = adv2;
  assign ctrl.load    = s2_type_q == ReqLoad;
  assign ctrl.mult    = s2_type_q == ReqMult;
  assign ctrl.row_end = s2_row_end_q;

  mvm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .prod_i      (s2_prod),
    .row_index_o (merge_row),
    .row_sum_o   (merge_sum)
  );

  always_ff @(posedge clk_i) begin
    if (adv2 && s2_emits) begin
      out_row_q <= merge_row;
      out_sum_q <= merge_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = out_sum_q;

endmodule

// File: dv/matrix_vector_multiply_unit_test.sv
// Self-checking testbench for the matrix-vector multiply unit with a built-in row predictor.
module matrix_vector_multiply_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mvm_pkg::*;

  localparam int unsigned HoldoffCycles = 300;

  typedef elem_t [Elems-1:0] quad_t;

  typedef struct packed {
    logic  kind;
    idx_t  chunk;
    quad_t elem;
    logic  last;
  } beat_t;

  typedef struct packed {
    row_t row_idx;
    sum_t row_val;
  } row_result_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  logic  req_type_i = ReqLoad;
  idx_t  chunk_index_i = '0;
  elem_t elem_0_i = '0;
  elem_t elem_1_i = '0;
  elem_t elem_2_i = '0;
  elem_t elem_3_i = '0;
  logic  row_end_i = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  row_t  row_index_o;
  sum_t  row_sum_o;

  beat_t       beats_to_send [$];
  beat_t       next_beat;
  row_result_t rows_due [$];
  row_result_t want;

  quad_t vec_mem [StoreSlots];
  sum_t  row_acc = '0;
  row_t  row_cnt = '0;

  bit    chunk_loaded [StoreSlots];
  idx_t  loaded_list [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_req = 0;
  int unsigned holdoff_ack = 0;
  int unsigned holdoff_left = 0;
  int unsigned err_cnt = 0;
  int unsigned beats_in = 0;
  int unsigned rows_out = 0;

  matrix_vector_multiply_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .chunk_index_i(chunk_index_i),
    .elem_0_i     (elem_0_i),
    .elem_1_i     (elem_1_i),
    .elem_2_i     (elem_2_i),
    .elem_3_i     (elem_3_i),
    .row_end_i    (row_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_index_o  (row_index_o),
    .row_sum_o    (row_sum_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= next_beat.kind;
        chunk_index_i <= next_beat.chunk;
        elem_0_i      <= next_beat.elem[0];
        elem_1_i      <= next_beat.elem[1];
        elem_2_i      <= next_beat.elem[2];
        elem_3_i      <= next_beat.elem[3];
        row_end_i     <= next_beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      holdoff_ack  <= 0;
      holdoff_left <= 0;
    end else if (holdoff_ack != holdoff_req) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HoldoffCycles;
      out_ready_i  <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void accumulate_beat(input beat_t b);
    longint chunk_sum;
    longint total;
    if (b.kind == ReqLoad) begin
      vec_mem[b.chunk] = b.elem;
      row_acc = '0;
      row_cnt = '0;
    end else begin
      chunk_sum = 0;
      for (int k = 0; k < Elems; k++) begin
        chunk_sum += longint'(elem_t'(b.elem[k])) * longint'(elem_t'(vec_mem[b.chunk][k]));
      end
      total = longint'(row_acc) + chunk_sum;
      if (total > longint'(SumMax)) begin
        row_acc = SumMax;
      end else if (total < longint'(SumMin)) begin
        row_acc = SumMin;
      end else begin
        row_acc = sum_t'(total);
      end
      if (b.last) begin
        rows_due.push_back('{row_idx: row_cnt, row_val: row_acc});
        row_acc = '0;
        row_cnt = row_cnt + 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rows_out++;
        if (rows_due.size() == 0) begin
          $error("unexpected row result: row_index %0d row_sum %0d", row_index_o, row_sum_o);
          err_cnt++;
        end else begin
          want = rows_due.pop_front();
          if (row_index_o !== want.row_idx) begin
            $error("row_index: expected %0d, actual %0d", want.row_idx, row_index_o);
            err_cnt++;
          end
          if (row_sum_o !== want.row_val) begin
            $error("row_sum: expected %0d, actual %0d", want.row_val, row_sum_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        beats_in++;
        accumulate_beat('{kind: req_type_i, chunk: chunk_index_i,
                          elem: {elem_3_i, elem_2_i, elem_1_i, elem_0_i}, last: row_end_i});
      end
    end
  end

  function automatic elem_t pick_elem();
    case ($urandom_range(9))
      0:       return {1'b1, {(ElemW-1){1'b0}}};
      1:       return {1'b0, {(ElemW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic quad_t quad(input elem_t e0, input elem_t e1, input elem_t e2,
                                 input elem_t e3);
    quad_t q;
    q[0] = e0;
    q[1] = e1;
    q[2] = e2;
    q[3] = e3;
    return q;
  endfunction

  function automatic quad_t rand_quad();
    return quad(pick_elem(), pick_elem(), pick_elem(), pick_elem());
  endfunction

  function automatic void queue_beat(input logic kind, input idx_t idx, input quad_t q,
                                     input logic last);
    beats_to_send.push_back('{kind: kind, chunk: idx, elem: q, last: last});
    if (kind == ReqLoad && !chunk_loaded[idx]) begin
      chunk_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endfunction

  function automatic void queue_row(input int unsigned n, input logic closed);
    idx_t idx;
    for (int unsigned i = 0; i < n; i++) begin
      idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
      queue_beat(ReqMult, idx, rand_quad(), closed && (i == n - 1));
    end
  endfunction

  task automatic drain();
    while (beats_to_send.size() != 0 || in_valid_i) @(negedge clk_i);
    while (rows_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned n_beats);
    int unsigned len;
    set_idling(send_pct, recv_pct);
    while (beats_to_send.size() < n_beats) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
      case ($urandom_range(19))
        0: queue_beat(ReqLoad, idx_t'($urandom), rand_quad(), 1'($urandom));
        1: begin
          queue_row(len, 1'b0);
          queue_beat(ReqLoad, idx_t'($urandom), rand_quad(), 1'($urandom));
        end
        default: queue_row(len, 1'b1);
      endcase
    end
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    elem_t emin;
    elem_t emax;
    idx_t  order [$];
    emin = {1'b1, {(ElemW-1){1'b0}}};
    emax = {1'b0, {(ElemW-1){1'b1}}};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idling(0, 0);
    queue_beat(ReqLoad, 8'd0, quad(emin, emax, 16'sd0, -16'sd1), 1'b1);
    queue_beat(ReqLoad, 8'd255, quad(16'sd1, -16'sd1, emax, emin), 1'b0);
    queue_beat(ReqLoad, 8'd1, rand_quad(), 1'b0);
    queue_beat(ReqMult, 8'd0, quad(emin, emin, emax, 16'sd1), 1'b0);
    queue_beat(ReqMult, 8'd255, quad(emax, emin, -16'sd1, 16'sd0), 1'b1);
    queue_beat(ReqMult, 8'd1, quad(emax, emax, emax, emax), 1'b1);
    queue_beat(ReqMult, 8'd0, quad(16'sd0, 16'sd0, 16'sd0, 16'sd0), 1'b1);
    queue_beat(ReqMult, 8'd255, rand_quad(), 1'b0);
    queue_beat(ReqLoad, 8'd2, rand_quad(), 1'b0);
    queue_beat(ReqMult, 8'd2, rand_quad(), 1'b1);
    queue_beat(ReqMult, 8'd0, quad(emin, emin, emin, emin), 1'b0);
    queue_beat(ReqMult, 8'd0, quad(emin, emin, emin, emin), 1'b1);
    drain();

    for (int i = 0; i < StoreSlots; i++) order.push_back(idx_t'(i));
    order.shuffle();
    foreach (order[i]) queue_beat(ReqLoad, order[i], rand_quad(), 1'($urandom));
    drain();

    random_phase(0, 0, 75);
    random_phase(75, 0, 75);
    random_phase(0, 75, 75);
    random_phase(9, 9, 75);

    // The receiver holds off while full rows keep arriving, so the pipeline backs up.
    set_idling(0, 0);
    holdoff_req++;
    for (int i = 0; i < 40; i++) queue_row($urandom_range(2, 1), 1'b1);
    drain();

    repeat (10) @(posedge clk_i);
    $display("summary: %0d beats in, %0d row results checked under idle, stall and hold-off",
             beats_in, rows_out);
    $display("summary: full vector sweep, extreme elements and mixed load and row beats covered");
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: matrix_vector_multiply_unit.f
sv/mvm_pkg.sv
sv/mvm_lane.sv
sv/mvm_merge.sv
sv/matrix_vector_multiply_unit.sv
dv/matrix_vector_multiply_unit_test.sv
